[sv/tmfe_pkg.sv]
// package for the text message feature extractor
// shared constants, command/status structs and byte codes; no dependencies
package tmfe_pkg;
    localparam int COUNT_BITS_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VALUE_BITS        = 40;
    localparam int NUM_FEATURES      = 11;
    localparam int INDEX_BITS        = 4;
    localparam logic [7:0] SHORT_MAX_RESET = 8'd2;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_EXCLAIM = 8'h21;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    localparam logic [INDEX_BITS-1:0] FEAT_LAST = 4'd10;

    // controller to datapath
    typedef struct packed {
        logic                  take_byte;   // accepted byte, update counters
        logic                  div_start;   // load operands for current feature
        logic                  div_step;    // one quotient bit
        logic                  clear;       // clear counters after message
        logic [INDEX_BITS-1:0] feature;     // feature being computed
    } tmfe_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } tmfe_status_t;
endpackage

[sv/tmfe_if.sv]
// valid/ready channel interfaces for the feature extractor
// no dependencies
interface tmfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_message;
    modport source (output valid, char_byte, end_of_message, input ready);
    modport sink (input valid, char_byte, end_of_message, output ready);
endinterface

interface tmfe_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  feature_index;
    logic [39:0] feature_value;
    logic        divide_by_zero;
    logic        last_feature;
    modport source (output valid, feature_index, feature_value, divide_by_zero,
                    last_feature, input ready);
    modport sink (input valid, feature_index, feature_value, divide_by_zero,
                  last_feature, output ready);
endinterface

interface tmfe_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[sv/tmfe_datapath.sv]
// counters, byte classifier and a restoring bit-serial divider
// depends on tmfe_pkg
module tmfe_datapath
    import tmfe_pkg::*;
#(
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tmfe_cmd_t               cmd,
    output tmfe_status_t            status,
    input  logic [7:0]              char_byte,
    input  logic                    end_of_message,
    input  logic [7:0]              short_max,
    output logic [VALUE_BITS-1:0]   value,
    output logic                    dz
);
    localparam int NUM_BITS  = COUNT_BITS + FRACTION_BITS;   // dividend width
    localparam int STEP_BITS = $clog2(NUM_BITS + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

    logic [COUNT_BITS-1:0] chr_reg, let_reg, dig_reg, blk_reg, pun_reg, oth_reg;
    logic [COUNT_BITS-1:0] wrd_reg, shw_reg, sen_reg;
    logic [7:0]            wlen_reg;
    logic                  armed_reg;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == CMAX) ? c : c + 1'b1;
    endfunction

    logic is_let, is_dig, is_blk, is_pun, is_nl, is_delim, sent_b;
    logic [COUNT_BITS-1:0] wrd_next, shw_next, sen_next;
    logic [7:0]            wlen_next;
    logic                  armed_next;

    always_comb
    begin
        is_nl  = char_byte == CH_NEWLINE;
        is_let = (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
                 (char_byte >= 8'h61 && char_byte <= 8'h7A);
        is_dig = char_byte >= 8'h30 && char_byte <= 8'h39;
        is_blk = char_byte == CH_SPACE || char_byte == CH_TAB;
        is_pun = char_byte == CH_PERIOD || char_byte == CH_QUEST ||
                 char_byte == CH_EXCLAIM;
        is_delim = is_nl || char_byte == CH_SEMI || char_byte == CH_COMMA ||
                   char_byte == CH_SPACE || is_pun;
        // word closes on a delimiter or at end of message
        wlen_next = is_delim ? 8'd0 : ((wlen_reg == 8'hFF) ? wlen_reg : wlen_reg + 8'd1);
        wrd_next = wrd_reg;
        shw_next = shw_reg;
        if (is_delim && wlen_reg != 8'd0)
        begin
            wrd_next = sat_inc(wrd_reg);
            if (wlen_reg <= short_max)
                shw_next = sat_inc(shw_reg);
        end
        else if (!is_delim && end_of_message)
        begin
            wrd_next = sat_inc(wrd_reg);
            if (wlen_next <= short_max)
                shw_next = sat_inc(shw_reg);
        end
        armed_next = armed_reg;
        sen_next   = sen_reg;
        sent_b     = is_blk && armed_reg;
        if (sent_b)
        begin
            armed_next = 1'b0;
            sen_next   = sat_inc(sen_reg);
        end
        if (is_pun)
            armed_next = 1'b1;
        if (end_of_message && armed_next)
        begin
            armed_next = 1'b0;
            sen_next   = sat_inc(sen_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chr_reg <= '0; let_reg <= '0; dig_reg <= '0; blk_reg <= '0;
            pun_reg <= '0; oth_reg <= '0; wrd_reg <= '0; shw_reg <= '0;
            sen_reg <= '0; wlen_reg <= '0; armed_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            chr_reg <= '0; let_reg <= '0; dig_reg <= '0; blk_reg <= '0;
            pun_reg <= '0; oth_reg <= '0; wrd_reg <= '0; shw_reg <= '0;
            sen_reg <= '0; wlen_reg <= '0; armed_reg <= 1'b0;
        end
        else if (cmd.take_byte)
        begin
            chr_reg <= sat_inc(chr_reg);
            if (!is_nl)
            begin
                if (is_let)      let_reg <= sat_inc(let_reg);
                else if (is_dig) dig_reg <= sat_inc(dig_reg);
                else if (is_blk) blk_reg <= sat_inc(blk_reg);
                else if (is_pun) pun_reg <= sat_inc(pun_reg);
                else             oth_reg <= sat_inc(oth_reg);
            end
            wrd_reg   <= wrd_next;
            shw_reg   <= shw_next;
            sen_reg   <= sen_next;
            wlen_reg  <= end_of_message ? 8'd0 : wlen_next;
            armed_reg <= armed_next;
        end
    end

    // operand select for the current feature
    logic [COUNT_BITS-1:0] num_sel, den_sel;
    logic                  is_ratio;
    always_comb
    begin
        num_sel  = chr_reg;
        den_sel  = chr_reg;
        is_ratio = 1'b1;
        case (cmd.feature)
            4'd0: num_sel = let_reg;
            4'd1: num_sel = dig_reg;
            4'd2: num_sel = blk_reg;
            4'd3: num_sel = pun_reg;
            4'd4: num_sel = oth_reg;
            4'd5: begin num_sel = chr_reg; is_ratio = 1'b0; end
            4'd6: begin num_sel = wrd_reg; is_ratio = 1'b0; end
            4'd7: begin num_sel = shw_reg; is_ratio = 1'b0; end
            4'd8: begin num_sel = let_reg; den_sel = wrd_reg; end
            4'd9: begin num_sel = chr_reg; den_sel = sen_reg; end
            4'd10: begin num_sel = wrd_reg; den_sel = sen_reg; end
            default: is_ratio = 1'b0;
        endcase
    end

    // restoring divider, one quotient bit per cycle; count features pass as den 1
    logic [NUM_BITS-1:0]   quo_reg;
    logic [COUNT_BITS:0]   rem_reg;
    logic [COUNT_BITS-1:0] den_reg;
    logic [STEP_BITS-1:0]  steps_reg;
    logic                  dz_reg;
    logic [COUNT_BITS:0]   trial;

    assign trial = {rem_reg[COUNT_BITS-1:0], quo_reg[NUM_BITS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            steps_reg <= '0;
        else if (cmd.div_start)
            steps_reg <= STEP_BITS'(NUM_BITS);
        else if (cmd.div_step && steps_reg != '0)
            steps_reg <= steps_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= {num_sel, {FRACTION_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= is_ratio ? den_sel : COUNT_BITS'(1);
            dz_reg  <= is_ratio && den_sel == '0;
        end
        else if (cmd.div_step && steps_reg != '0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign status.div_done = steps_reg == '0;
    assign dz = dz_reg;

    generate
        if (NUM_BITS > VALUE_BITS)
        begin : g_sat
            assign value = dz_reg ? VMAX :
                ((quo_reg[NUM_BITS-1:VALUE_BITS] != '0) ? VMAX
                                                        : quo_reg[VALUE_BITS-1:0]);
        end
        else
        begin : g_nosat
            assign value = dz_reg ? VMAX : VALUE_BITS'(quo_reg);
        end
    endgenerate
endmodule

[sv/tmfe_ctrl.sv]
// controller state machine: byte intake, per-feature divide, result handoff
// depends on tmfe_pkg
module tmfe_ctrl
    import tmfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [INDEX_BITS-1:0] out_index,
    output tmfe_cmd_t             cmd,
    input  tmfe_status_t          status
);
    typedef enum logic [1:0] {S_IDLE, S_START, S_DIV, S_OUT} state_t;

    state_t                state_reg;
    logic [INDEX_BITS-1:0] feat_reg;
    logic                  take;

    assign in_ready  = state_reg == S_IDLE;
    assign take      = in_valid && in_ready;
    assign out_valid = state_reg == S_OUT;
    assign out_index = feat_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.take_byte = take;
        cmd.feature   = feat_reg;
        cmd.div_start = state_reg == S_START;
        cmd.div_step  = state_reg == S_DIV;
        cmd.clear     = state_reg == S_OUT && out_ready && feat_reg == FEAT_LAST;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            feat_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (take && in_last)
                    begin
                        feat_reg  <= '0;
                        state_reg <= S_START;
                    end
                S_START: state_reg <= S_DIV;
                S_DIV:   if (status.div_done) state_reg <= S_OUT;
                S_OUT:
                    if (out_ready)
                    begin
                        if (feat_reg == FEAT_LAST)
                            state_reg <= S_IDLE;
                        else
                        begin
                            feat_reg  <= feat_reg + 1'b1;
                            state_reg <= S_START;
                        end
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during output");
    a_feat_range: assert property (@(posedge clk) disable iff (!rst_n)
        feat_reg <= FEAT_LAST) else $error("feature index out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(feat_reg))
        else $error("result dropped");
endmodule

[sv/text_message_feature_extractor.sv]
// top level of the text message feature extractor
// depends on tmfe_pkg, tmfe_if, tmfe_ctrl, tmfe_datapath
//
// Bytes enter one per cycle while the controller is idle and only update
// saturating counters. The byte that carries end_of_message starts the feature
// phase: input is held off while eleven results come out in index order, each
// from a shared restoring divider that produces one quotient bit per cycle.
// Each feature passes a load state, a divide state that runs until the divider
// is done, and an output state that holds the item until it is taken; the next
// byte is taken only after the last feature has been handed over.
// Ratios are truncated, saturated to 2^40-1, and flagged on a zero divisor.
module text_message_feature_extractor
    import tmfe_pkg::*;
#(
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    tmfe_in_if.sink   in_ch,
    tmfe_out_if.source out_ch,
    tmfe_cfg_if.sink  cfg
);
    tmfe_cmd_t    cmd;
    tmfe_status_t status;
    logic [7:0]   short_max_reg;

    // config register, always writable
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            short_max_reg <= SHORT_MAX_RESET;
        else if (cfg.valid)
            short_max_reg <= cfg.data;
    end

    tmfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.end_of_message),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_index (out_ch.feature_index),
        .cmd       (cmd),
        .status    (status)
    );

    tmfe_datapath #(
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .char_byte      (in_ch.char_byte),
        .end_of_message (in_ch.end_of_message),
        .short_max      (short_max_reg),
        .value          (out_ch.feature_value),
        .dz             (out_ch.divide_by_zero)
    );

    // last flag follows the index
    assign out_ch.last_feature = out_ch.feature_index == FEAT_LAST;
endmodule
